### design/rbd_pkg.sv
// Package for the ring buffer deque.
// Holds the transaction structs, operation and status codes and default sizes.
// No dependencies.
package rbd_pkg;

  localparam int WORD_W      = 32;
  localparam int OCC_W       = 8;
  localparam int DEPTH_DFLT  = 128;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_POP_FRONT  = 2'd1;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic capture;
  } rbd_cmd_t;

  typedef struct packed {
    logic need_read;
  } rbd_stat_t;

endpackage

### design/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/rbd_ctrl.sv
// Controller for the ring buffer deque: sequences accept, store read and result hand-off.
// Depends on rbd_pkg.
module rbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rbd_pkg::rbd_stat_t stat,
  output rbd_pkg::rbd_cmd_t  cmd
);
  import rbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.capture = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = stat.need_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/rbd_dp.sv
// Datapath for the ring buffer deque: indices, count, word store and result register.
// Depends on rbd_pkg and rbd_ram.
module rbd_dp #(
  parameter int DEPTH = rbd_pkg::DEPTH_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rbd_pkg::in_item_t  in_data,
  input  rbd_pkg::rbd_cmd_t  cmd,
  output rbd_pkg::rbd_stat_t stat,
  output rbd_pkg::out_item_t out_data
);
  import rbd_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [IW-1:0] front_r, front_nxt;
  logic [IW-1:0] rear_r, rear_nxt;
  logic [CW-1:0] count_r, count_nxt;
  out_item_t     res_r, res_nxt;

  logic          is_push, is_front, full, empty;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [CW+OCC_W-1:0] occ_wide;

  assign is_push  = (in_data.func == OP_PUSH_FRONT) || (in_data.func == OP_PUSH_BACK);
  assign is_front = (in_data.func == OP_PUSH_FRONT) || (in_data.func == OP_POP_FRONT);
  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);

  assign stat.need_read = !is_push && !empty;
  assign rd_addr        = is_front ? front_r : rear_r;

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    res_nxt   = res_r;
    if (cmd.accept) begin
      res_nxt.pop_value = '0;
      res_nxt.status    = ST_DONE;
      if (is_push) begin
        if (full) begin
          res_nxt.status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          if (empty) begin
            front_nxt = '0;
            rear_nxt  = '0;
          end else if (is_front) begin
            front_nxt = (front_r == '0) ? IDX_LAST : front_r - IW'(1);
            wr_addr   = front_nxt;
          end else begin
            rear_nxt = (rear_r == IDX_LAST) ? '0 : rear_r + IW'(1);
            wr_addr  = rear_nxt;
          end
        end
      end else begin
        if (empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            front_nxt = '0;
            rear_nxt  = '0;
          end else if (is_front) begin
            front_nxt = (front_r == IDX_LAST) ? '0 : front_r + IW'(1);
          end else begin
            rear_nxt = (rear_r == '0) ? IDX_LAST : rear_r - IW'(1);
          end
        end
      end
      occ_wide           = {{OCC_W{1'b0}}, count_nxt};
      res_nxt.occupancy  = occ_wide[OCC_W-1:0];
      res_nxt.is_empty   = (count_nxt == '0);
    end else begin
      occ_wide = '0;
    end
    if (cmd.capture) begin
      res_nxt.pop_value = $signed(rd_data);
    end
  end

  rbd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.push_value),
    .rd_en   (cmd.accept && stat.need_read),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_data = res_r;

endmodule

### design/ring_buffer_deque.sv
// Top level of the ring buffer deque: joins controller and datapath.
// Depends on rbd_pkg, rbd_ctrl, rbd_dp and rbd_ram.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request per
//   transaction: push front, pop front, push back or pop back, with the
//   word to push. Output channel out_valid/out_ready/out_data returns one
//   result per request: popped word (zero unless a pop succeeds), status,
//   occupancy after the step and an empty flag.
//   A refused push (deque full) or pop (deque empty) leaves the state intact.
//   One request is in flight at a time. A push or refused pop shows its
//   result in the cycle after acceptance; a successful pop first passes a
//   read state, set by the registered read port of the word store.
//   The block is ready again in the cycle after the result is taken.
//   While out_ready is low the result is held and no request is accepted.
//   Reset empties the deque; store contents need no clearing.
module ring_buffer_deque #(
  parameter int DEPTH = rbd_pkg::DEPTH_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rbd_pkg::out_item_t out_data
);
  import rbd_pkg::*;

  rbd_cmd_t  cmd;
  rbd_stat_t stat;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
